>>> hw/rtl/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg: shared types and constants for the linear solver
// Fixed-point helpers and status codes used by the solver modules.
// ----------------------------------------------------------------------------
package gls_pkg;

  localparam logic [1:0] STATUS_SOLVED   = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_COUNT    = 2'd2;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/gls_ram.sv
// ----------------------------------------------------------------------------
// gls_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/gls_div.sv
// ----------------------------------------------------------------------------
// gls_div: sequential Q16.16 divider
// Computes (num * 2^16) / den truncated toward zero, saturated, one bit a cycle.
// ----------------------------------------------------------------------------
module gls_div
  import gls_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  output logic               done,
  output logic signed [31:0] quot
);
  logic [47:0] dividend;
  logic [31:0] divisor;
  logic [48:0] rem;
  logic [47:0] q;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [48:0] trial;
  logic signed [63:0] sq;

  assign trial = {rem[47:0], dividend[47]} - {17'd0, divisor};
  assign sq    = neg ? -$signed({16'd0, q}) : $signed({16'd0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        cnt      <= 6'd48;
        neg      <= req.num[31] ^ req.den[31];
        dividend <= {(req.num[31] ? 32'(-req.num) : 32'(req.num)), 16'd0};
        divisor  <= req.den[31] ? 32'(-req.den) : 32'(req.den);
        rem      <= '0;
        q        <= '0;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial;
          q   <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[47:0], dividend[47]};
          q   <= {q[46:0], 1'b0};
        end
        dividend <= {dividend[46:0], 1'b0};
        cnt      <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = sat32(sq);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(req.start && busy))
    else $error("divider started while busy");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0)
    else $error("divider count underflow");
endmodule

>>> hw/rtl/gaussian_linear_solver.sv
// ----------------------------------------------------------------------------
// gaussian_linear_solver: fixed-point Gaussian elimination solver
// Loads A and b, eliminates with row exchange, back-substitutes, emits x.
// ----------------------------------------------------------------------------
// Elements load at one item per cycle while in_stall is low, into a single
// augmented-matrix RAM. On load_end the solver walks the RAM: each elimination
// row update takes a quotient from the shared serial divider plus, per column,
// a pivot-row read, a target-row read and a multiply with write back; no item
// is accepted until all results are delivered. Results leave through an output
// register, each after a read of the solution RAM and only while that register
// is free.
module gaussian_linear_solver
  import gls_pkg::*;
#(
  parameter int MAX_N = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  input  logic               load_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] solution,
  output logic [2:0]         index,
  output logic               final_res,
  output logic [1:0]         status
);
  localparam int CAP  = MAX_N * (MAX_N + 1);
  localparam int AW   = $clog2(CAP + 2);
  localparam int RW   = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW   = $clog2(MAX_N + 1);
  localparam int MW   = $clog2(CAP);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_PIV   = 4'd1;
  localparam logic [3:0] S_PIVW  = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_ROWRD = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_BSRD  = 4'd7;
  localparam logic [3:0] S_BSACC = 4'd8;
  localparam logic [3:0] S_BSDIV = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_ONE   = 4'd11;

  logic [3:0]  matrix_size;
  logic [15:0] pivot_epsilon;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size   <= 4'd8;
      pivot_epsilon <= 16'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) matrix_size <= pwdata[3:0];
      else if (paddr == 3'd4) pivot_epsilon <= pwdata[15:0];
    end
  end
  assign prdata = (paddr == 3'd0) ? {28'd0, matrix_size} :
                  (paddr == 3'd4) ? {16'd0, pivot_epsilon} : 32'd0;

  logic [3:0]  state;
  logic [AW-1:0] load_count;
  logic [CW-1:0] n;
  logic [RW-1:0] row_order [MAX_N];
  logic [CW-1:0] i, k, j, e;
  logic signed [31:0] piv, fac, acc, tmp;
  logic [1:0]  ph;
  logic [RW-1:0] ri;

  // Matrix RAM: row-major by physical row, width n+1 (b in last column).
  logic          m_we;
  logic [MW-1:0] m_wa, m_ra;
  logic [31:0]   m_wd, m_rd;
  gls_ram #(.WIDTH(32), .DEPTH(CAP)) u_mat (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  logic          x_we;
  logic [RW-1:0] x_wa, x_ra;
  logic [31:0]   x_wd, x_rd;
  gls_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_sol (
    .clk(clk), .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(x_ra), .rdata(x_rd)
  );

  div_req_t dreq;
  logic dv_done;
  logic signed [31:0] dv_q;
  gls_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(dv_done), .quot(dv_q));

  logic [CW-1:0] n_cfg;
  always_comb begin
    if (matrix_size == 4'd0) n_cfg = CW'(1);
    else if (32'(matrix_size) > MAX_N) n_cfg = CW'(MAX_N);
    else n_cfg = CW'(matrix_size);
  end

  // Loaded element address maps stream order to row-major augmented layout.
  logic [MW-1:0] ld_addr;
  logic [31:0] lc32, nn, r32, c32;
  always_comb begin
    lc32 = 32'(load_count);
    nn   = 32'(n_cfg) * 32'(n_cfg);
    if (lc32 < nn) begin
      r32 = 32'd0;
      c32 = 32'd0;
      for (int t = 0; t < MAX_N; t++)
        if (lc32 >= 32'(t) * 32'(n_cfg) && lc32 < 32'(t + 1) * 32'(n_cfg)) begin
          r32 = 32'(t);
          c32 = lc32 - 32'(t) * 32'(n_cfg);
        end
    end else begin
      r32 = lc32 - nn;
      c32 = 32'(n_cfg);
    end
    ld_addr = MW'(r32 * (32'(n_cfg) + 32'd1) + c32);
  end

  function automatic logic [MW-1:0] maddr(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                          input logic [CW-1:0] nsz);
    return MW'(32'(r) * (32'(nsz) + 32'd1) + 32'(c));
  endfunction

  logic signed [63:0] prod;
  logic signed [63:0] pq;
  logic signed [31:0] mag_rd;
  logic below_rd, above_rd;
  // Row updates multiply the factor by the captured pivot-row entry.
  assign prod = (state == S_UPD) ? 64'(fac) * 64'(tmp) :
                64'($signed(m_rd)) * 64'($signed(x_rd));
  assign pq   = prod / 65536;
  assign mag_rd = m_rd[31] ? -$signed(m_rd) : $signed(m_rd);
  assign below_rd = (m_rd == 32'd0) ||
                    ({1'b0, mag_rd} < {17'd0, pivot_epsilon} && !(m_rd == 32'h80000000));
  assign above_rd = (m_rd == 32'h80000000) || ({1'b0, mag_rd} > {17'd0, pivot_epsilon});

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_LOAD) || !out_free;

  always_comb begin
    ri = row_order[i[RW-1:0]];
    m_we = 1'b0; m_wa = ld_addr; m_wd = value; m_ra = '0;
    x_we = 1'b0; x_wa = ri; x_wd = dv_q; x_ra = '0;
    dreq = '0;
    case (state)
      S_LOAD: begin
        m_we = in_valid && !in_stall && (32'(load_count) < CAP) &&
               (lc32 < 32'(n_cfg) * (32'(n_cfg) + 1));
      end
      S_PIV: m_ra = maddr(ri, i, n);
      S_SRCH: m_ra = maddr(row_order[k[RW-1:0]], i, n);
      S_ROWRD: m_ra = maddr(row_order[k[RW-1:0]], i, n);
      S_UPD: begin
        m_ra = (ph == 2'd0) ? maddr(ri, j, n) : maddr(row_order[k[RW-1:0]], j, n);
        m_we = (ph == 2'd3);
        m_wa = maddr(row_order[k[RW-1:0]], j, n);
        m_wd = sat32(64'($signed(m_rd)) - pq);
      end
      S_BSRD: m_ra = maddr(ri, n, n);
      S_BSACC: begin
        m_ra = maddr(ri, j, n);
        x_ra = j[RW-1:0];
      end
      S_BSDIV: begin
        m_ra = maddr(ri, i, n);
        x_we = dv_done;
        x_wa = i[RW-1:0];
      end
      S_EMIT: x_ra = e[RW-1:0];
      default: ;
    endcase
    if (state == S_DIV && ph == 2'd0) begin
      dreq.start = 1'b1; dreq.num = m_rd; dreq.den = piv;
    end
    if (state == S_BSDIV && ph == 2'd1) begin
      dreq.start = 1'b1; dreq.num = acc; dreq.den = m_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      load_count <= '0;
      out_valid <= 1'b0;
      ph <= '0;
      for (int t = 0; t < MAX_N; t++) row_order[t] <= RW'(t);
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_LOAD: if (in_valid && !in_stall) begin
          if (load_end) begin
            load_count <= '0;
            n <= n_cfg;
            for (int t = 0; t < MAX_N; t++) row_order[t] <= RW'(t);
            if (32'(load_count) + 1 != 32'(n_cfg) * (32'(n_cfg) + 1)) begin
              status <= STATUS_COUNT; state <= S_ONE;
            end else begin
              i <= '0; state <= S_PIV; ph <= '0;
            end
          end else if (32'(load_count) < CAP + 1) load_count <= load_count + AW'(1);
        end
        S_PIV: state <= S_PIVW;
        S_PIVW: begin
          if (below_rd) begin
            k <= i + CW'(1); state <= S_SRCH; ph <= '0;
          end else begin
            piv <= m_rd; k <= i + CW'(1); state <= S_ROWRD; ph <= '0;
          end
        end
        S_SRCH: begin
          // Wait for the registered row read to land, then test it.
          if (k >= n) begin
            status <= STATUS_SINGULAR; state <= S_ONE;
          end else if (ph == 2'd0) ph <= 2'd1;
          else begin
            ph <= '0;
            if (above_rd) begin
              row_order[i[RW-1:0]] <= row_order[k[RW-1:0]];
              row_order[k[RW-1:0]] <= row_order[i[RW-1:0]];
              piv <= m_rd; k <= i + CW'(1); state <= S_ROWRD;
            end else if (k + CW'(1) < n) k <= k + CW'(1);
            else begin
              status <= STATUS_SINGULAR; state <= S_ONE;
            end
          end
        end
        S_ROWRD: begin
          if (k >= n) begin
            if (i + CW'(1) < n) begin
              i <= i + CW'(1); state <= S_PIV;
            end else begin
              i <= n - CW'(1); state <= S_BSRD;
            end
          end else state <= S_DIV;
          ph <= '0;
        end
        S_DIV: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (dv_done) begin
            fac <= dv_q; j <= i; ph <= '0; state <= S_UPD;
          end
        end
        S_UPD: begin
          case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin tmp <= m_rd; ph <= 2'd3; end
            default: begin
              ph <= '0;
              if (j == n) begin
                k <= k + CW'(1); state <= S_ROWRD;
              end else j <= j + CW'(1);
            end
          endcase
        end
        S_BSRD: begin
          if (ph == 2'd0) ph <= 2'd1;
          else begin
            acc <= m_rd; j <= i + CW'(1); ph <= '0; state <= S_BSACC;
          end
        end
        S_BSACC: begin
          if (j >= n) begin
            ph <= '0; state <= S_BSDIV;
          end else if (ph == 2'd0) ph <= 2'd1;
          else begin
            acc <= sat32(64'(acc) - (prod / 65536)); j <= j + CW'(1); ph <= '0;
          end
        end
        S_BSDIV: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (ph == 2'd1) ph <= 2'd2;
          else if (dv_done) begin
            ph <= '0;
            if (i == '0) begin
              e <= '0; state <= S_EMIT;
            end else begin
              i <= i - CW'(1); state <= S_BSRD;
            end
          end
        end
        S_EMIT: begin
          if (ph == 2'd0) ph <= 2'd1;
          else if (out_free) begin
            out_valid <= 1'b1;
            solution <= x_rd;
            index <= 3'(e);
            final_res <= (e == n - CW'(1));
            status <= STATUS_SOLVED;
            ph <= '0;
            if (e == n - CW'(1)) state <= S_LOAD;
            else e <= e + CW'(1);
          end
        end
        S_ONE: if (out_free) begin
          out_valid <= 1'b1; solution <= '0; index <= '0; final_res <= 1'b1;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(solution) && $stable(index))
    else $error("result overwritten while stalled");
  a_in_closed: assert property (@(posedge clk) disable iff (rst)
    state != S_LOAD |-> in_stall)
    else $error("input open during solve");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(load_count) <= CAP + 1)
    else $error("load count overrun");
endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the fixed-point linear solver
// Loads augmented systems through the item port, predicts each solution,
// singular or count-error result in a scoreboard, and checks every result.
// ----------------------------------------------------------------------------
module tb_top
  import gls_pkg::*;
();

  localparam int CAP = 8 * 9;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic [2:0] REG_SIZE = 3'd0;
  localparam logic [2:0] REG_EPS = 3'd4;
  localparam logic signed [31:0] Q1 = 32'sh0001_0000;

  typedef struct {
    logic signed [31:0] sol;
    logic [2:0] idx;
    logic fin;
    logic [1:0] st;
  } answer_t;

  class solver_scoreboard;
    logic [31:0] store [CAP];
    int unsigned load_cnt;
    int unsigned size_reg;
    int unsigned eps;
    longint sol_mem [8];
    answer_t answers [$];
    int errors;
    int checked;

    function new();
      load_cnt = 0;
      size_reg = 8;
      eps = 1;
      errors = 0;
      checked = 0;
    endfunction

    function automatic longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function automatic longint qdiv(longint num, longint den);
      return sat((num * 65536) / den);
    endfunction

    function automatic longint qmul(longint a, longint b);
      return (a * b) / 65536;
    endfunction

    function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function automatic bit tiny(longint p);
      return (p == 0) || (mag(p) < longint'(eps));
    endfunction

    function automatic void push_one(logic [1:0] code);
      answer_t a;
      a.sol = 0;
      a.idx = 0;
      a.fin = 1;
      a.st = code;
      answers.push_back(a);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Notes an accepted item and queues whatever results it causes.
    function automatic void note_item(logic signed [31:0] v, logic last);
      longint w [8][9];
      int ord [8];
      int n, cnt, t;
      answer_t a;
      if (load_cnt < CAP) store[load_cnt] = v;
      if (load_cnt < CAP + 1) load_cnt++;
      if (!last) return;
      cnt = load_cnt;
      load_cnt = 0;
      n = (size_reg < 1) ? 1 : (size_reg > 8) ? 8 : size_reg;
      if (cnt != n * (n + 1)) begin
        push_one(STATUS_COUNT);
        return;
      end
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) w[r][c] = longint'($signed(store[r * n + c]));
        w[r][n] = longint'($signed(store[n * n + r]));
        ord[r] = r;
      end
      for (int i = 0; i < n; i++) begin
        if (tiny(w[ord[i]][i])) begin
          for (int k = i + 1; k < n; k++) begin
            if (mag(w[ord[k]][i]) > longint'(eps)) begin
              t = ord[i];
              ord[i] = ord[k];
              ord[k] = t;
              break;
            end
          end
        end
        if (tiny(w[ord[i]][i])) begin
          push_one(STATUS_SINGULAR);
          return;
        end
        for (int k = i + 1; k < n; k++) begin
          longint f;
          f = qdiv(w[ord[k]][i], w[ord[i]][i]);
          for (int j = i; j <= n; j++)
            w[ord[k]][j] = sat(w[ord[k]][j] - qmul(f, w[ord[i]][j]));
        end
      end
      for (int i = n - 1; i >= 0; i--) begin
        longint acc;
        acc = w[ord[i]][n];
        for (int j = i + 1; j < n; j++) acc = sat(acc - qmul(w[ord[i]][j], sol_mem[j]));
        sol_mem[i] = qdiv(acc, w[ord[i]][i]);
      end
      for (int i = 0; i < n; i++) begin
        a.sol = sol_mem[i][31:0];
        a.idx = i[2:0];
        a.fin = (i == n - 1);
        a.st = STATUS_SOLVED;
        answers.push_back(a);
      end
    endfunction

    task check_result(logic signed [31:0] sol, logic [2:0] idx, logic fin, logic [1:0] st);
      answer_t a;
      checked++;
      if (answers.size() == 0) begin
        report($sformatf("unexpected result solution=%0d index=%0d", sol, idx));
        return;
      end
      a = answers.pop_front();
      if (sol !== a.sol) report($sformatf("solution %0d, expected %0d", sol, a.sol));
      if (idx !== a.idx) report($sformatf("index %0d, expected %0d", idx, a.idx));
      if (fin !== a.fin) report($sformatf("final_res %0b, expected %0b", fin, a.fin));
      if (st !== a.st) report($sformatf("status %0d, expected %0d", st, a.st));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] value = 0;
  logic load_end = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] solution;
  logic [2:0] index;
  logic final_res;
  logic [1:0] status;

  solver_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int size_now = 8;
  int hold_left = 0;
  bit hold_done = 0;

  gaussian_linear_solver dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(value, load_end);
      if (out_valid && !out_stall) sb.check_result(solution, index, final_res, status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: stall density steps through three modes (none, light, heavy); one long
  // hold-off backs the block up while the sender keeps offering items.
  always @(negedge clk) begin
    int mode;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (!hold_done && sb.checked >= 10 && out_valid && in_valid) begin
      hold_done = 1;
      hold_left = 500;
      out_stall <= 1;
    end else begin
      mode = int'(($time / 512) % 3);
      case (mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == REG_SIZE) sb.size_reg = data & 32'hF;
    else sb.eps = data & 32'hFFFF;
  endtask

  task send_item(logic signed [31:0] v, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1;
    value <= v;
    load_end <= last;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Waits for all results, lets the block settle, then writes both registers.
  task set_config(int unsigned size, int unsigned eps);
    in_valid <= 0;
    while (sb.answers.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    apb_write(REG_SIZE, size);
    apb_write(REG_EPS, eps);
    size_now = (size < 1) ? 1 : (size > 8) ? 8 : size;
  endtask

  function automatic logic signed [31:0] rand_entry(bit diag);
    int r;
    logic signed [31:0] v;
    r = $urandom_range(0, 19);
    if (r == 0) v = $urandom;
    else if (r == 1) begin
      case ($urandom_range(0, 4))
        0: v = 32'sh7fffffff;
        1: v = 32'sh80000000;
        2: v = 0;
        3: v = 1;
        default: v = -1;
      endcase
    end else if (r == 2) v = $signed($urandom_range(0, 600)) - 300;
    else v = $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    if (diag && r > 2 && $urandom_range(0, 9) < 6)
      v = v + (($urandom_range(0, 1) == 1) ? 8 * Q1 : -8 * Q1);
    return v;
  endfunction

  task send_system(int len);
    int n;
    n = size_now;
    for (int k = 0; k < len; k++)
      send_item(rand_entry(k < n * n && (k / n) == (k % n)), k == len - 1);
  endtask

  initial begin
    int n, len, reps;
    int unsigned sizes [8] = '{1, 3, 2, 0, 15, 4, 5, 2};
    int unsigned epss [8] = '{0, 1, 65535, 300, 0, 1, 65535, 1};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    set_config(2, 1);
    // Identity, swapped rows, all zero, and the signed extremes.
    send_item(Q1, 0); send_item(0, 0); send_item(0, 0); send_item(Q1, 0);
    send_item(3 * Q1, 0); send_item(-2 * Q1, 1);
    send_item(0, 0); send_item(Q1, 0); send_item(Q1, 0); send_item(0, 0);
    send_item(5 * Q1, 0); send_item(7, 1);
    repeat (5) send_item(0, 0);
    send_item(0, 1);
    send_item(32'sh7fffffff, 0); send_item(32'sh80000000, 0);
    send_item(32'sh80000000, 0); send_item(32'sh7fffffff, 0);
    send_item(32'sh7fffffff, 0); send_item(32'sh80000000, 1);
    // Load that ends early.
    send_item(Q1, 0); send_item(Q1, 0); send_item(Q1, 1);

    // Surplus elements beyond storage.
    set_config(1, 1);
    for (int k = 0; k < 74; k++) send_item(rand_entry(0), k == 73);

    for (int p = 0; p < 8; p++) begin
      set_config(sizes[p], epss[p]);
      reps = (size_now <= 3) ? 2 : 1;
      for (int s = 0; s < reps; s++) begin
        n = size_now;
        len = n * (n + 1);
        if ($urandom_range(0, 9) == 0) len = len + ($urandom_range(0, 1) ? 1 : -1);
        if (len < 1) len = 2;
        send_system(len);
      end
    end

    in_valid <= 0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
